// File: sv/mciir_pkg.sv
package mciir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 2;
  localparam int MODE_W   = 2;
  localparam int COEF_W   = 24;
  localparam int HIST_W   = 40;
  localparam int IDX_W    = 3;
  localparam int NUM_LAGS = 4;

  localparam int DEF_NUM_CHANNELS = 3;
  localparam int DEF_MAX_ORDER    = 4;

  // stages 1 to 4 hold items whose history has not been written back
  localparam int HAZ_SLOTS = 4;

  localparam logic [IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_INPUT_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_LAG1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_LAG2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_LAG3 = 3'd4;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_LAG4 = 3'd5;

  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FOURTH = 2'd3;

  localparam logic [MODE_W-1:0]        MODE_RST = MODE_FOURTH;
  localparam logic signed [COEF_W-1:0] GAIN_RST = 24'sd41537;
  localparam logic signed [COEF_W-1:0] LAG1_RST = 24'sd7363124;
  localparam logic signed [COEF_W-1:0] LAG2_RST = -24'sd5586847;
  localparam logic signed [COEF_W-1:0] LAG3_RST = 24'sd2056564;
  localparam logic signed [COEF_W-1:0] LAG4_RST = -24'sd303128;

  typedef struct packed {
    logic [MODE_W-1:0]                 mode;
    logic [COEF_W-1:0]                 gain;
    logic [NUM_LAGS-1:0][COEF_W-1:0]   lag;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] channel;
  } slot_t;

  function automatic logic [2:0] order_of(input logic [MODE_W-1:0] mode);
    logic [2:0] ord;
    unique case (mode)
      MODE_BYPASS: ord = 3'd0;
      MODE_FIRST:  ord = 3'd1;
      MODE_SECOND: ord = 3'd2;
      MODE_FOURTH: ord = 3'd4;
    endcase
    return ord;
  endfunction

  function automatic logic [2:0] binom_weight(input logic [2:0] ord, input logic [2:0] j);
    logic [2:0] w;
    w = 3'd0;
    case (ord)
      3'd1: begin
        case (j)
          3'd1:    w = 3'd1;
          default: w = 3'd0;
        endcase
      end
      3'd2: begin
        case (j)
          3'd1:    w = 3'd2;
          3'd2:    w = 3'd1;
          default: w = 3'd0;
        endcase
      end
      3'd4: begin
        case (j)
          3'd1:    w = 3'd4;
          3'd2:    w = 3'd6;
          3'd3:    w = 3'd4;
          3'd4:    w = 3'd1;
          default: w = 3'd0;
        endcase
      end
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/mciir_cfg.sv
module mciir_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [mciir_pkg::IDX_W-1:0]   write_index,
  input  logic [mciir_pkg::COEF_W-1:0]  write_data,
  output mciir_pkg::cfg_t               cfg
);
  import mciir_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_RST;
      cfg.gain   <= GAIN_RST;
      cfg.lag[0] <= LAG1_RST;
      cfg.lag[1] <= LAG2_RST;
      cfg.lag[2] <= LAG3_RST;
      cfg.lag[3] <= LAG4_RST;
    end else if (write_enable) begin
      unique case (write_index)
        REG_FILTER_MODE:   cfg.mode   <= write_data[MODE_W-1:0];
        REG_INPUT_GAIN:    cfg.gain   <= write_data;
        REG_FEEDBACK_LAG1: cfg.lag[0] <= write_data;
        REG_FEEDBACK_LAG2: cfg.lag[1] <= write_data;
        REG_FEEDBACK_LAG3: cfg.lag[2] <= write_data;
        REG_FEEDBACK_LAG4: cfg.lag[3] <= write_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/mciir_hist_mem.sv
module mciir_hist_mem #(
  parameter int NUM_CHANNELS = mciir_pkg::DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = mciir_pkg::DEF_MAX_ORDER,
  parameter int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         rd_en,
  input  logic [CH_AW-1:0]                             rd_addr,
  output logic [MAX_ORDER-1:0][mciir_pkg::HIST_W-1:0]  rd_row,
  input  logic                                         wr_en,
  input  logic [CH_AW-1:0]                             wr_addr,
  input  logic [MAX_ORDER-1:0][mciir_pkg::HIST_W-1:0]  wr_row
);
  import mciir_pkg::*;

  localparam int ROWS2 = 1 << CH_AW;

  logic [MAX_ORDER-1:0][HIST_W-1:0] mem [NUM_CHANNELS];
  logic [MAX_ORDER-1:0][HIST_W-1:0] rd_data;
  logic [ROWS2-1:0]                 written;
  logic                             rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  // a row never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_written ? rd_data : '0;

endmodule

// File: sv/mciir_pipe.sv
module mciir_pipe #(
  parameter int NUM_CHANNELS = mciir_pkg::DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = mciir_pkg::DEF_MAX_ORDER,
  parameter int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  mciir_pkg::cfg_t                                     cfg,
  input  logic                                                in_accept,
  input  logic signed [mciir_pkg::SAMPLE_W-1:0]               in_sample,
  input  logic [mciir_pkg::CH_W-1:0]                          in_channel,
  output logic                                                in_free,
  input  logic [MAX_ORDER-1:0][mciir_pkg::HIST_W-1:0]         hist_row,
  output logic                                                wr_en,
  output logic [CH_AW-1:0]                                    wr_addr,
  output logic [MAX_ORDER-1:0][mciir_pkg::HIST_W-1:0]         wr_row,
  output mciir_pkg::slot_t [mciir_pkg::HAZ_SLOTS-1:0]         busy,
  input  logic                                                out_stall,
  output logic                                                out_valid,
  output logic signed [mciir_pkg::SAMPLE_W-1:0]               out_data
);
  import mciir_pkg::*;

  typedef enum logic [1:0] {
    KIND_FILTER = 2'd0,
    KIND_PASS   = 2'd1,
    KIND_ZERO   = 2'd2
  } kind_t;

  localparam int NST = 6;
  localparam logic [4:0] NCH = 5'(NUM_CHANNELS);
  localparam logic [2:0] MORD = 3'(MAX_ORDER);
  localparam logic signed [63:0] RND22  = 64'sd2097152;
  localparam logic signed [45:0] ACC_HI = 46'sd549755813887;
  localparam logic signed [45:0] ACC_LO = -46'sd549755813888;
  localparam logic signed [30:0] Y_HI   = 31'sd32767;
  localparam logic signed [30:0] Y_LO   = -31'sd32768;

  typedef logic [MAX_ORDER-1:0][HIST_W-1:0] row_t;

  logic [NST:1] v;
  logic [NST:1] free;

  // stage 1
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [CH_W-1:0]            s1_ch;
  kind_t                      s1_kind;
  logic [2:0]                 s1_ord;
  kind_t                      in_kind;
  logic [2:0]                 in_ord;

  // stage 2
  logic signed [39:0]         s2_gp;
  logic signed [44:0]         s2_lo [MAX_ORDER];
  logic signed [43:0]         s2_hi [MAX_ORDER];
  logic signed [43:0]         s2_wh [MAX_ORDER];
  row_t                       s2_hist;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic [CH_W-1:0]            s2_ch;
  kind_t                      s2_kind;
  logic [2:0]                 s2_ord;

  // stage 3
  logic signed [34:0]         s3_g;
  logic signed [41:0]         s3_t [MAX_ORDER];
  logic signed [44:0]         s3_bsa;
  logic signed [44:0]         s3_bsb;
  row_t                       s3_hist;
  logic signed [SAMPLE_W-1:0] s3_x;
  logic [CH_W-1:0]            s3_ch;
  kind_t                      s3_kind;
  logic signed [40:0]         g_sum;
  logic signed [63:0]         t_full [MAX_ORDER];
  logic signed [44:0]         bsa_sum;
  logic signed [44:0]         bsb_sum;

  // stage 4
  logic signed [44:0]         s4_sa;
  logic signed [44:0]         s4_sb;
  logic signed [45:0]         s4_bs;
  row_t                       s4_hist;
  logic signed [SAMPLE_W-1:0] s4_x;
  logic [CH_W-1:0]            s4_ch;
  kind_t                      s4_kind;
  logic signed [44:0]         sa_sum;
  logic signed [44:0]         sb_sum;
  logic signed [45:0]         tot;
  logic signed [HIST_W-1:0]   acc;

  // stage 5
  logic signed [HIST_W-1:0]   s5_acc;
  logic signed [45:0]         s5_bs;
  logic signed [SAMPLE_W-1:0] s5_x;
  kind_t                      s5_kind;
  logic signed [46:0]         y_sum;
  logic signed [30:0]         y_q;
  logic signed [SAMPLE_W-1:0] y_sat;

  // stage 6: output register
  logic signed [SAMPLE_W-1:0] s6_y;

  always_comb begin
    free[NST] = !v[NST] || !out_stall;
    for (int i = NST - 1; i >= 1; i--) begin
      free[i] = !v[i] || free[i+1];
    end
  end

  assign in_free = free[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[1]) begin
        v[1] <= in_accept;
      end
      for (int i = 2; i <= NST; i++) begin
        if (free[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // classify at entry
  always_comb begin
    in_ord = order_of(cfg.mode);
    if (5'(in_channel) >= NCH) begin
      in_kind = KIND_ZERO;
    end else if (in_ord == 3'd0 || in_ord > MORD) begin
      in_kind = KIND_PASS;
    end else begin
      in_kind = KIND_FILTER;
    end
  end

  always_ff @(posedge clk) begin
    if (free[1]) begin
      s1_x    <= in_sample;
      s1_ch   <= in_channel;
      s1_kind <= in_kind;
      s1_ord  <= in_ord;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (free[2]) begin
      s2_gp <= $signed(cfg.gain) * s1_x;
      for (int k = 0; k < MAX_ORDER; k++) begin
        s2_lo[k] <= $signed(cfg.lag[k]) * $signed({1'b0, hist_row[k][19:0]});
        s2_hi[k] <= $signed(cfg.lag[k]) * $signed(hist_row[k][HIST_W-1:20]);
        s2_wh[k] <= $signed({1'b0, binom_weight(s1_ord, 3'(k + 1))})
                    * $signed(hist_row[k]);
      end
      s2_hist <= hist_row;
      s2_x    <= s1_x;
      s2_ch   <= s1_ch;
      s2_kind <= s1_kind;
      s2_ord  <= s1_ord;
    end
  end

  // rejoin partial products and round each term
  always_comb begin
    g_sum   = 41'(s2_gp) + 41'sd32;
    bsa_sum = '0;
    bsb_sum = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      t_full[k] = (64'(s2_hi[k]) <<< 20) + 64'(s2_lo[k]) + RND22;
      if (k < 2) begin
        bsa_sum = bsa_sum + 45'(s2_wh[k]);
      end else begin
        bsb_sum = bsb_sum + 45'(s2_wh[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[3]) begin
      s3_g <= g_sum[40:6];
      for (int k = 0; k < MAX_ORDER; k++) begin
        s3_t[k] <= (3'(k) < s2_ord) ? t_full[k][63:22] : '0;
      end
      s3_bsa  <= bsa_sum;
      s3_bsb  <= bsb_sum;
      s3_hist <= s2_hist;
      s3_x    <= s2_x;
      s3_ch   <= s2_ch;
      s3_kind <= s2_kind;
    end
  end

  always_comb begin
    sa_sum = 45'(s3_g);
    sb_sum = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (k < 2) begin
        sa_sum = sa_sum + 45'(s3_t[k]);
      end else begin
        sb_sum = sb_sum + 45'(s3_t[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[4]) begin
      s4_sa   <= sa_sum;
      s4_sb   <= sb_sum;
      s4_bs   <= 46'(s3_bsa) + 46'(s3_bsb);
      s4_hist <= s3_hist;
      s4_x    <= s3_x;
      s4_ch   <= s3_ch;
      s4_kind <= s3_kind;
    end
  end

  // new recursion value, write back shifted history
  always_comb begin
    tot = 46'(s4_sa) + 46'(s4_sb);
    if (tot > ACC_HI) begin
      acc = ACC_HI[HIST_W-1:0];
    end else if (tot < ACC_LO) begin
      acc = ACC_LO[HIST_W-1:0];
    end else begin
      acc = tot[HIST_W-1:0];
    end
    wr_row[0] = acc;
    for (int k = 1; k < MAX_ORDER; k++) begin
      wr_row[k] = s4_hist[k-1];
    end
  end

  assign wr_en   = v[4] && free[5] && (s4_kind == KIND_FILTER);
  assign wr_addr = CH_AW'(s4_ch);

  always_ff @(posedge clk) begin
    if (free[5]) begin
      s5_acc  <= acc;
      s5_bs   <= s4_bs;
      s5_x    <= s4_x;
      s5_kind <= s4_kind;
    end
  end

  always_comb begin
    y_sum = 47'(s5_acc) + 47'(s5_bs) + 47'sd32768;
    y_q   = y_sum[46:16];
    if (y_q > Y_HI) begin
      y_sat = Y_HI[SAMPLE_W-1:0];
    end else if (y_q < Y_LO) begin
      y_sat = Y_LO[SAMPLE_W-1:0];
    end else begin
      y_sat = y_q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (free[6]) begin
      case (s5_kind)
        KIND_FILTER: s6_y <= y_sat;
        KIND_PASS:   s6_y <= s5_x;
        default:     s6_y <= '0;
      endcase
    end
  end

  assign out_valid = v[NST];
  assign out_data  = s6_y;

  assign busy[0] = '{valid: v[1] && (s1_kind == KIND_FILTER), channel: s1_ch};
  assign busy[1] = '{valid: v[2] && (s2_kind == KIND_FILTER), channel: s2_ch};
  assign busy[2] = '{valid: v[3] && (s3_kind == KIND_FILTER), channel: s3_ch};
  assign busy[3] = '{valid: v[4] && (s4_kind == KIND_FILTER), channel: s4_ch};

endmodule

// File: sv/multichannel_iir_lowpass.sv
// channel   direction  handshake                       payload
// sample    in         sample_valid / sample_stall     sample, channel
// filtered  out        filtered_valid / filtered_stall filtered
// config    in         write_enable                    write_index, write_data
//
// Six-stage pipeline, one item per cycle across channels unless filtered_stall or a
// same-channel hazard holds it. History lives in one row-per-channel memory, read
// at accept and written back from stage 4, so an item waits while a filtering item of
// its channel is in stages 1 to 4 and has not yet written back.
// Reset clears config to defaults and per-channel written bits; no clearing pass.
// A stalled result holds in the output register; empty stages still take items.
module multichannel_iir_lowpass #(
  parameter int NUM_CHANNELS = mciir_pkg::DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = mciir_pkg::DEF_MAX_ORDER
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [mciir_pkg::SAMPLE_W-1:0] sample,
  input  logic [mciir_pkg::CH_W-1:0]           channel,
  output logic                                 filtered_valid,
  input  logic                                 filtered_stall,
  output logic signed [mciir_pkg::SAMPLE_W-1:0] filtered,
  input  logic                                 write_enable,
  input  logic [mciir_pkg::IDX_W-1:0]          write_index,
  input  logic [mciir_pkg::COEF_W-1:0]         write_data
);
  import mciir_pkg::*;

  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cfg_t                             cfg;
  slot_t [HAZ_SLOTS-1:0]            busy;
  logic                             in_free;
  logic                             hazard;
  logic                             accept;
  logic [MAX_ORDER-1:0][HIST_W-1:0] hist_row;
  logic                             wr_en;
  logic [CH_AW-1:0]                 wr_addr;
  logic [MAX_ORDER-1:0][HIST_W-1:0] wr_row;
  logic                             dup;

  mciir_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  mciir_hist_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_ORDER    (MAX_ORDER),
    .CH_AW        (CH_AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_free),
    .rd_addr (CH_AW'(channel)),
    .rd_row  (hist_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  mciir_pipe #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_ORDER    (MAX_ORDER),
    .CH_AW        (CH_AW)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_accept  (accept),
    .in_sample  (sample),
    .in_channel (channel),
    .in_free    (in_free),
    .hist_row   (hist_row),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_row     (wr_row),
    .busy       (busy),
    .out_stall  (filtered_stall),
    .out_valid  (filtered_valid),
    .out_data   (filtered)
  );

  // hold an item whose channel still has a write-back pending
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < HAZ_SLOTS; i++) begin
      if (busy[i].valid && busy[i].channel == channel) begin
        hazard = 1'b1;
      end
    end
  end

  assign sample_stall = !in_free || hazard;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < HAZ_SLOTS; i++) begin
      for (int j = i + 1; j < HAZ_SLOTS; j++) begin
        if (busy[i].valid && busy[j].valid && busy[i].channel == busy[j].channel) begin
          dup = 1'b1;
        end
      end
    end
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (5'(wr_addr) < 5'(NUM_CHANNELS)))
    else $error("history write to a channel out of range");

  a_no_dup_channel: assert property (@(posedge clk) disable iff (rst)
    !dup)
    else $error("two items of one channel in flight before write-back");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !filtered_valid)
    else $error("result valid right after reset");

endmodule
